### hw/rtl/ldfws_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ldfws_pkg
// Shared types, constants and tables of the LED frame store / encoder.
// ============================================================================
package ldfws_pkg;

  localparam int NUM_LEDS       = 64;
  localparam int LEDS_PER_DIGIT = 13;
  localparam int DIGIT_GAP      = 2;   // extra offset for positions 2 and 3
  localparam int NUM_DIGITS     = 10;

  localparam int IDX_W    = 6;         // width of LED index fields
  localparam int ADDR_W   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int DIG_W    = IDX_W + 1; // digit end before clipping
  localparam int COLOUR_W = 24;
  localparam int BYTE_W   = 8;
  localparam int BITS_PER_LED = 24;
  localparam int BIT_CNT_W    = $clog2(BITS_PER_LED);

  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_ZERO_PAT = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_ONE_PAT  = CFG_ADDR_W'(1);

  localparam logic [BYTE_W-1:0] ZERO_PAT_RST = 8'd192;
  localparam logic [BYTE_W-1:0] ONE_PAT_RST  = 8'd248;

  typedef enum logic [1:0] {
    ACT_FILL_ALL   = 2'd0,
    ACT_FILL_RANGE = 2'd1,
    ACT_DRAW_DIGIT = 2'd2,
    ACT_EMIT_LED   = 2'd3
  } action_e;

  typedef struct packed {
    logic                we;
    logic                re;
    logic [ADDR_W-1:0]   addr;
    logic [COLOUR_W-1:0] wdata;
  } ram_req_t;

  // Lit LEDs of digits 0..9, bit i = LED i of the digit.
  function automatic logic [LEDS_PER_DIGIT-1:0] digit_mask(input logic [3:0] digit);
    logic [LEDS_PER_DIGIT-1:0] m;
    case (digit)
      4'd0:    m = 13'h0FFF;
      4'd1:    m = 13'h007C;
      4'd2:    m = 13'h17DF;
      4'd3:    m = 13'h15FF;
      4'd4:    m = 13'h1C7D;
      4'd5:    m = 13'h1DF7;
      4'd6:    m = 13'h1FF7;
      4'd7:    m = 13'h007F;
      4'd8:    m = 13'h1FFF;
      4'd9:    m = 13'h1DFF;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [IDX_W-1:0] digit_base(input logic [1:0] pos);
    int b;
    b = int'(pos) * LEDS_PER_DIGIT + ((pos > 2'd1) ? DIGIT_GAP : 0);
    return IDX_W'(b);
  endfunction

endpackage

### hw/rtl/ldfws_frame_store.sv
`timescale 1ns / 1ps
// ============================================================================
// ldfws_frame_store
// Colour memory, one word per LED, one write and one registered read port.
// Per-entry valid bits make unwritten LEDs read as black after reset.
// ============================================================================
module ldfws_frame_store (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ldfws_pkg::ram_req_t              req_i,
  output logic [ldfws_pkg::COLOUR_W-1:0]   rdata_o
);

  logic [ldfws_pkg::COLOUR_W-1:0] mem_q [ldfws_pkg::NUM_LEDS];
  logic [ldfws_pkg::NUM_LEDS-1:0] valid_q;
  logic [ldfws_pkg::COLOUR_W-1:0] rdata_q;
  logic                           rvalid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.addr] <= 1'b1;
      end
      if (req_i.re) begin
        rvalid_q <= valid_q[req_i.addr];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

### hw/rtl/ldfws_serializer.sv
`timescale 1ns / 1ps
// ============================================================================
// ldfws_serializer
// Turns one LED colour into 24 pattern bytes, MSB of green first.
// ============================================================================
module ldfws_serializer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  logic [ldfws_pkg::COLOUR_W-1:0]   colour_i,
  input  logic [ldfws_pkg::BYTE_W-1:0]     zero_pat_i,
  input  logic [ldfws_pkg::BYTE_W-1:0]     one_pat_i,
  output logic                             busy_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ldfws_pkg::BYTE_W-1:0]     out_byte_o,
  output logic                             out_last_o
);

  localparam logic [ldfws_pkg::BIT_CNT_W-1:0] LAST_BIT =
    ldfws_pkg::BIT_CNT_W'(ldfws_pkg::BITS_PER_LED - 1);

  logic [ldfws_pkg::COLOUR_W-1:0]  shift_q;
  logic [ldfws_pkg::BIT_CNT_W-1:0] cnt_q;
  logic                            active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else if (load_i && !active_q) begin
      active_q <= 1'b1;
      cnt_q    <= '0;
    end else if (active_q && out_ready_i) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LAST_BIT) begin
        active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && !active_q) begin
      shift_q <= colour_i;
    end else if (active_q && out_ready_i) begin
      shift_q <= {shift_q[ldfws_pkg::COLOUR_W-2:0], 1'b0};
    end
  end

  assign busy_o      = active_q;
  assign out_valid_o = active_q;
  assign out_byte_o  = shift_q[ldfws_pkg::COLOUR_W-1] ? one_pat_i : zero_pat_i;
  assign out_last_o  = (cnt_q == LAST_BIT);

endmodule

### hw/rtl/ldfws_sequencer.sv
`timescale 1ns / 1ps
// ============================================================================
// ldfws_sequencer
// Takes one command at a time and walks the frame memory: fills and digits
// step one LED per cycle (a digit writes only lit LEDs); an emit reads one
// LED and hands it to the serializer.
// ============================================================================
module ldfws_sequencer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  ldfws_pkg::action_e               action_i,
  input  logic [ldfws_pkg::IDX_W-1:0]      first_led_i,
  input  logic [ldfws_pkg::IDX_W-1:0]      last_led_i,
  input  logic [1:0]                       digit_pos_i,
  input  logic [3:0]                       digit_value_i,
  input  logic [ldfws_pkg::COLOUR_W-1:0]   colour_i,
  output ldfws_pkg::ram_req_t              ram_req_o,
  input  logic [ldfws_pkg::COLOUR_W-1:0]   ram_rdata_i,
  input  logic                             ser_busy_i,
  output logic                             ser_load_o,
  output logic [ldfws_pkg::COLOUR_W-1:0]   ser_colour_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_LOAD
  } state_e;

  localparam logic [ldfws_pkg::ADDR_W-1:0] LAST_ADDR =
    ldfws_pkg::ADDR_W'(ldfws_pkg::NUM_LEDS - 1);

  state_e                              state_q;
  logic [ldfws_pkg::ADDR_W-1:0]        walk_addr_q;
  logic [ldfws_pkg::ADDR_W-1:0]        walk_end_q;
  logic [ldfws_pkg::LEDS_PER_DIGIT-1:0] mask_q;
  logic                                use_mask_q;
  logic                                emit_zero_q;
  logic [ldfws_pkg::COLOUR_W-1:0]      colour_q;

  logic                          accept;
  logic                          first_in;
  logic [ldfws_pkg::ADDR_W-1:0]  range_end;
  logic [ldfws_pkg::IDX_W-1:0]   dig_base;
  logic [ldfws_pkg::DIG_W-1:0]   dig_end_raw;
  logic                          dig_base_in;
  logic [ldfws_pkg::ADDR_W-1:0]  dig_end;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign first_in  = int'(first_led_i) < ldfws_pkg::NUM_LEDS;
  assign range_end = (int'(last_led_i) >= ldfws_pkg::NUM_LEDS) ? LAST_ADDR
                                                               : ldfws_pkg::ADDR_W'(last_led_i);

  assign dig_base    = ldfws_pkg::digit_base(digit_pos_i);
  assign dig_end_raw = ldfws_pkg::DIG_W'(dig_base)
                     + ldfws_pkg::DIG_W'(ldfws_pkg::LEDS_PER_DIGIT - 1);
  assign dig_base_in = int'(dig_base) < ldfws_pkg::NUM_LEDS;
  assign dig_end     = (int'(dig_end_raw) >= ldfws_pkg::NUM_LEDS) ? LAST_ADDR
                                                                  : ldfws_pkg::ADDR_W'(dig_end_raw);

  always_comb begin
    ram_req_o       = '0;
    ram_req_o.wdata = colour_q;
    if (state_q == S_WALK) begin
      ram_req_o.we   = !use_mask_q || mask_q[0];
      ram_req_o.addr = walk_addr_q;
    end else begin
      // emit read goes out in the accept cycle
      ram_req_o.re   = accept && (action_i == ldfws_pkg::ACT_EMIT_LED) && first_in;
      ram_req_o.addr = ldfws_pkg::ADDR_W'(first_led_i);
    end
  end

  assign ser_load_o   = (state_q == S_LOAD) && !ser_busy_i;
  assign ser_colour_o = emit_zero_q ? '0 : ram_rdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      walk_addr_q <= '0;
      walk_end_q  <= '0;
      mask_q      <= '0;
      use_mask_q  <= 1'b0;
      emit_zero_q <= 1'b0;
      colour_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            colour_q <= colour_i;
            case (action_i)
              ldfws_pkg::ACT_FILL_ALL: begin
                walk_addr_q <= '0;
                walk_end_q  <= LAST_ADDR;
                use_mask_q  <= 1'b0;
                state_q     <= S_WALK;
              end
              ldfws_pkg::ACT_FILL_RANGE: begin
                if (first_in && !(last_led_i < first_led_i)) begin
                  walk_addr_q <= ldfws_pkg::ADDR_W'(first_led_i);
                  walk_end_q  <= range_end;
                  use_mask_q  <= 1'b0;
                  state_q     <= S_WALK;
                end
              end
              ldfws_pkg::ACT_DRAW_DIGIT: begin
                if (int'(digit_value_i) < ldfws_pkg::NUM_DIGITS && dig_base_in) begin
                  walk_addr_q <= ldfws_pkg::ADDR_W'(dig_base);
                  walk_end_q  <= dig_end;
                  mask_q      <= ldfws_pkg::digit_mask(digit_value_i);
                  use_mask_q  <= 1'b1;
                  state_q     <= S_WALK;
                end
              end
              ldfws_pkg::ACT_EMIT_LED: begin
                emit_zero_q <= !first_in;
                state_q     <= S_LOAD;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_WALK: begin
          if (walk_addr_q == walk_end_q) begin
            state_q <= S_IDLE;
          end else begin
            walk_addr_q <= walk_addr_q + 1'b1;
            mask_q      <= mask_q >> 1;
          end
        end
        S_LOAD: begin
          // hold the read word until the serializer has finished the last LED
          if (!ser_busy_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_write_only_walking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req_o.we |-> (state_q == S_WALK))
    else $error("frame write outside a walk");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_load_o |-> !ser_busy_i)
    else $error("serializer loaded while busy");

  a_walk_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (walk_addr_q <= walk_end_q))
    else $error("walk address passed its end");

  a_no_read_and_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req_o.we && ram_req_o.re))
    else $error("read and write in the same cycle");
`endif

endmodule

### hw/rtl/led_digit_frame_ws2812_encoder_core.sv
`timescale 1ns / 1ps
// ============================================================================
// led_digit_frame_ws2812_encoder_core
// LED frame store with digit drawing and WS2812 SPI byte encoding.
// ============================================================================
//  channel  dir  handshake                    payload
//  s_axis   in   s_axis_tvalid/s_axis_tready  tuser=action, tdata=LED fields
//  m_axis   out  m_axis_tvalid/m_axis_tready  tdata=spi_byte, tlast=last_of_run
//  cfg      in   cfg_valid_i/cfg_ready_o      cfg_addr_i=register, cfg_data_i
//
// Fills and digits walk the frame memory, whose write port takes one LED per
// cycle; a digit writes only its lit LEDs. An emit reads the memory and hands
// the colour to the serializer, which gives 24 output words at up to one per
// cycle; a further emit waits in the hand-over until the previous LED is out
// and holds off other commands; fills may run while no emit is waiting.
// Reset clears the frame to black at once via per-LED valid bits.
// ============================================================================
module led_digit_frame_ws2812_encoder_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [5:0] first_led, [11:6] last_led, [13:12] digit_pos, [17:14] digit_value,
  // [25:18] red, [33:26] green, [41:34] blue, [47:42] zero
  input  logic [47:0]                        s_axis_tdata,
  // [1:0] action
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [7:0] spi_byte
  output logic [7:0]                         m_axis_tdata,
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ldfws_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [ldfws_pkg::BYTE_W-1:0]       cfg_data_i
);

  logic [ldfws_pkg::BYTE_W-1:0]   zero_pat_q;
  logic [ldfws_pkg::BYTE_W-1:0]   one_pat_q;
  ldfws_pkg::ram_req_t            ram_req;
  logic [ldfws_pkg::COLOUR_W-1:0] ram_rdata;
  logic                           ser_busy;
  logic                           ser_load;
  logic [ldfws_pkg::COLOUR_W-1:0] ser_colour;
  logic [ldfws_pkg::COLOUR_W-1:0] in_colour;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_pat_q <= ldfws_pkg::ZERO_PAT_RST;
      one_pat_q  <= ldfws_pkg::ONE_PAT_RST;
    end else if (cfg_valid_i) begin
      if (cfg_addr_i == ldfws_pkg::REG_ZERO_PAT) begin
        zero_pat_q <= cfg_data_i;
      end else if (cfg_addr_i == ldfws_pkg::REG_ONE_PAT) begin
        one_pat_q <= cfg_data_i;
      end
    end
  end

  // stored as green, red, blue from the top
  assign in_colour = {s_axis_tdata[33:26], s_axis_tdata[25:18], s_axis_tdata[41:34]};

  ldfws_sequencer u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .action_i      (ldfws_pkg::action_e'(s_axis_tuser)),
    .first_led_i   (s_axis_tdata[5:0]),
    .last_led_i    (s_axis_tdata[11:6]),
    .digit_pos_i   (s_axis_tdata[13:12]),
    .digit_value_i (s_axis_tdata[17:14]),
    .colour_i      (in_colour),
    .ram_req_o     (ram_req),
    .ram_rdata_i   (ram_rdata),
    .ser_busy_i    (ser_busy),
    .ser_load_o    (ser_load),
    .ser_colour_o  (ser_colour)
  );

  ldfws_frame_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  ldfws_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (ser_load),
    .colour_i    (ser_colour),
    .zero_pat_i  (zero_pat_q),
    .one_pat_i   (one_pat_q),
    .busy_o      (ser_busy),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
